// ===== sv/wav_header_parser_defines.svh =====
// ----------------------------------------------------------------------------
// WAV header parser assertion macros
// Concurrent assertion helpers used by the parser core.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define WHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wav_header_parser: same-cycle check failed");

`define WHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wav_header_parser: next-cycle check failed");

`else

`define WHP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define WHP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/wavp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV header parser package
// Tag constants and the result word shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wavp_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [7:0] TAG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] TAG_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [7:0] TAG_FMT  [4] = '{8'h66, 8'h6d, 8'h74, 8'h20};
  localparam logic [7:0] TAG_DATA [4] = '{8'h64, 8'h61, 8'h74, 8'h61};

  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [31:0] FMT_BODY_MIN = 32'd16;

  localparam int unsigned ERR_RIFF    = 0;
  localparam int unsigned ERR_WAVE    = 1;
  localparam int unsigned ERR_FMT     = 2;
  localparam int unsigned ERR_NOT_PCM = 3;
  localparam int unsigned ERR_DATA    = 4;
  localparam int unsigned ErrW        = 5;

  // Packed so that header_done lands in bit 0 of the output word.
  typedef struct packed {
    logic        err_data;
    logic        err_not_pcm;
    logic        err_fmt;
    logic        err_wave;
    logic        err_riff;
    logic [31:0] data_bytes;
    logic [15:0] bits_per_sample;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        header_done;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutW    = ((ResultW + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== sv/wavp_in_reg.sv =====
// ----------------------------------------------------------------------------
// WAV header parser input register
// Holds one incoming file byte until the parser core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wavp_in_reg
  import wavp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [ByteW-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             take_i,
  output logic [ByteW-1:0]      data_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] data_q, data_d;
  logic             load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== sv/wavp_core.sv =====
// ----------------------------------------------------------------------------
// WAV header parser core
// Phase sequencer, tag checks and field capture for one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_header_parser_defines.svh"

module wavp_core
  import wavp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] byte_i,
  output result_t               res_o
);

  typedef enum logic [2:0] {
    PH_RIFF     = 3'd0,
    PH_WAVE     = 3'd1,
    PH_FMTTAG   = 3'd2,
    PH_FMTSIZE  = 3'd3,
    PH_FMTBODY  = 3'd4,
    PH_DATATAG  = 3'd5,
    PH_DATASIZE = 3'd6,
    PH_PAYLOAD  = 3'd7
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     fmt_q, fmt_d;
  logic [15:0]     fc_q, fc_d;
  logic [31:0]     rate_q, rate_d;
  logic [15:0]     chan_q, chan_d;
  logic [15:0]     bps_q, bps_d;
  logic [31:0]     data_q, data_d;
  logic [ErrW-1:0] err_q, err_d;

  logic [1:0]  lane;
  logic [31:0] body_last;
  logic        bps_ok;
  logic        pv;
  logic [7:0]  pb;

  assign lane      = pos_q[1:0];
  assign body_last = (fmt_q > FMT_BODY_MIN) ? (fmt_q - 32'd1) : (FMT_BODY_MIN - 32'd1);
  assign bps_ok    = (bps_q == 16'd8) || (bps_q == 16'd16) || (bps_q == 16'd32);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q + 32'd1;
    fmt_d   = fmt_q;
    fc_d    = fc_q;
    rate_d  = rate_q;
    chan_d  = chan_q;
    bps_d   = bps_q;
    data_d  = data_q;
    err_d   = err_q;
    pv      = 1'b0;
    pb      = '0;
    unique case (phase_q)
      PH_RIFF: begin
        if (pos_q[31:2] == '0 && byte_i != TAG_RIFF[lane]) err_d[ERR_RIFF] = 1'b1;
        if (pos_q >= 32'd7) begin
          phase_d = PH_WAVE;
          pos_d   = '0;
        end
      end
      PH_WAVE: begin
        if (byte_i != TAG_WAVE[lane]) err_d[ERR_WAVE] = 1'b1;
        if (pos_q >= 32'd3) begin
          phase_d = PH_FMTTAG;
          pos_d   = '0;
        end
      end
      PH_FMTTAG: begin
        if (lane != 2'd3 && byte_i != TAG_FMT[lane]) err_d[ERR_FMT] = 1'b1;
        if (pos_q >= 32'd3) begin
          phase_d = PH_FMTSIZE;
          pos_d   = '0;
        end
      end
      PH_FMTSIZE: begin
        fmt_d[{lane, 3'b000} +: 8] = byte_i;
        if (pos_q >= 32'd3) begin
          phase_d = PH_FMTBODY;
          pos_d   = '0;
        end
      end
      PH_FMTBODY: begin
        if (pos_q[31:4] == '0) begin
          if (pos_q[3:0] < 4'd2) begin
            fc_d[{pos_q[0], 3'b000} +: 8] = byte_i;
            if (pos_q[3:0] == 4'd1 && {byte_i, fc_q[7:0]} != FMT_PCM) begin
              err_d[ERR_NOT_PCM] = 1'b1;
            end
          end else if (pos_q[3:0] < 4'd4) begin
            chan_d[{pos_q[0], 3'b000} +: 8] = byte_i;
          end else if (pos_q[3:0] < 4'd8) begin
            rate_d[{lane, 3'b000} +: 8] = byte_i;
          end else if (pos_q[3:0] >= 4'd14) begin
            bps_d[{pos_q[0], 3'b000} +: 8] = byte_i;
          end
        end
        if (pos_q >= body_last) begin
          phase_d = PH_DATATAG;
          pos_d   = '0;
        end
      end
      PH_DATATAG: begin
        if (byte_i != TAG_DATA[lane]) err_d[ERR_DATA] = 1'b1;
        if (pos_q >= 32'd3) begin
          phase_d = PH_DATASIZE;
          pos_d   = '0;
        end
      end
      PH_DATASIZE: begin
        data_d[{lane, 3'b000} +: 8] = byte_i;
        if (pos_q >= 32'd3) begin
          phase_d = PH_PAYLOAD;
          pos_d   = '0;
        end
      end
      PH_PAYLOAD: begin
        pos_d = pos_q;
        if (err_q == '0 && bps_ok) begin
          pv = 1'b1;
          pb = byte_i;
        end
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      pos_q   <= '0;
      fmt_q   <= '0;
      fc_q    <= '0;
      rate_q  <= '0;
      chan_q  <= '0;
      bps_q   <= '0;
      data_q  <= '0;
      err_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      fmt_q   <= fmt_d;
      fc_q    <= fc_d;
      rate_q  <= rate_d;
      chan_q  <= chan_d;
      bps_q   <= bps_d;
      data_q  <= data_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    res_o.header_done     = (phase_d == PH_PAYLOAD);
    res_o.payload_valid   = pv;
    res_o.payload_byte    = pb;
    res_o.rate_hz         = rate_d;
    res_o.channel_count   = chan_d;
    res_o.bits_per_sample = bps_d;
    res_o.data_bytes      = data_d;
    res_o.err_riff        = err_d[ERR_RIFF];
    res_o.err_wave        = err_d[ERR_WAVE];
    res_o.err_fmt         = err_d[ERR_FMT];
    res_o.err_not_pcm     = err_d[ERR_NOT_PCM];
    res_o.err_data        = err_d[ERR_DATA];
  end

  `WHP_ASSERT_NXT(a_payload_holds, clk_i, rst_ni, phase_q == PH_PAYLOAD, phase_q == PH_PAYLOAD)
  `WHP_ASSERT_NXT(a_err_sticky, clk_i, rst_ni, 1'b1, (err_q & $past(err_q)) == $past(err_q))
  `WHP_ASSERT_IMP(a_pass_clean, clk_i, rst_ni, pv, err_q == '0 && phase_q == PH_PAYLOAD)
  `WHP_ASSERT_IMP(a_pos_short, clk_i, rst_ni, phase_q != PH_FMTBODY, pos_q[31:3] == '0)

endmodule

`default_nettype wire

// ===== sv/wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// WAV header parser
// Parses a RIFF/WAVE PCM header one byte per word and passes payload bytes.
// ----------------------------------------------------------------------------
//   Channel  Dir  Width  Content
//   s_axis   in   8      file byte
//   m_axis   out  112    flags, parsed header fields and payload byte
//
// Each accepted byte gives exactly one output word on m_axis: the byte is
// held in the input register and the core result is caught in the output
// register.
// The core handles one byte per cycle while m_axis does not stall, so both sides may move a word every cycle.
// Reset clears the phase, the counters, the fields and the error flags.
// A stall on m_axis holds the output word and stops the parser core; the input
// register still takes one more byte before s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_parser
  import wavp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [ByteW-1:0] s_axis_tdata,   // file_byte
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // header_done, payload_valid, payload_byte, rate_hz, channel_count,
  // bits_per_sample, data_bytes, err_riff, err_wave, err_fmt, err_not_pcm,
  // err_data, zero fill
  output logic [OutW-1:0]       m_axis_tdata
);

  logic             stage_valid;
  logic [ByteW-1:0] stage_byte;
  logic             step;
  result_t          res_next;
  result_t          res_q;
  logic             out_valid_q, out_valid_d;

  assign step = stage_valid && (!out_valid_q || m_axis_tready);

  wavp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .valid_o (stage_valid),
    .take_i  (step),
    .data_o  (stage_byte)
  );

  wavp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (stage_byte),
    .res_o  (res_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutW - ResultW){1'b0}}, res_q};

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Streams one WAV file into the parser a byte per word: a fixed header that
// sometimes carries one damaged tag or format byte, then random payload.
// Every output word is compared field by field with a byte-level model of
// the parser. Both ports idle and stall at random in several phases, and the
// output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wavp_pkg::*;

  typedef enum logic [2:0] {
    ST_RIFF, ST_WAVE, ST_FMT_TAG, ST_FMT_SIZE,
    ST_FMT_BODY, ST_DATA_TAG, ST_DATA_SIZE, ST_PAYLOAD
  } hdr_state_e;

  typedef enum logic [1:0] {PIN_NONE, PIN_CLEAR, PIN_DONE, PIN_PAYLOAD} pin_e;

  typedef struct {
    logic [7:0] data;
    pin_e       pin;
  } row_t;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned DrainCycles = 4;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic [7:0]      s_axis_tdata  = 8'h00;
  logic            m_axis_tready = 1'b0;
  wire             s_axis_tready;
  wire             m_axis_tvalid;
  wire [OutW-1:0]  m_axis_tdata;

  pin_e            cur_pin       = PIN_NONE;
  int unsigned     src_idle_pct  = 0;
  int unsigned     snk_stall_pct = 0;
  bit              hold_req      = 1'b0;
  bit              hold_started  = 1'b0;
  int unsigned     hold_left     = 0;
  int unsigned     err_count     = 0;
  result_t         expected_words[$];

  // Parser model state, starting from its reset values.
  hdr_state_e      st       = ST_RIFF;
  logic [31:0]     pos      = '0;
  logic [31:0]     fmt_size = '0;
  logic [15:0]     fmt_code = '0;
  logic [31:0]     rate     = '0;
  logic [15:0]     chans    = '0;
  logic [15:0]     bps      = '0;
  logic [31:0]     dsize    = '0;
  logic [ErrW-1:0] errs     = '0;

  wav_header_parser dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void step_pos(input logic [31:0] last);
    if (pos >= last) begin
      st  = hdr_state_e'(st + 1'b1);
      pos = '0;
    end else begin
      pos = pos + 1;
    end
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t     w;
    logic [1:0]  lane;
    logic [31:0] body_len;
    w        = '0;
    lane     = pos[1:0];
    body_len = (fmt_size > FMT_BODY_MIN) ? fmt_size : FMT_BODY_MIN;
    case (st)
      ST_RIFF: begin
        if (pos < 4 && b != TAG_RIFF[lane]) errs[ERR_RIFF] = 1'b1;
        step_pos(32'd7);
      end
      ST_WAVE: begin
        if (b != TAG_WAVE[lane]) errs[ERR_WAVE] = 1'b1;
        step_pos(32'd3);
      end
      ST_FMT_TAG: begin
        if (lane < 3 && b != TAG_FMT[lane]) errs[ERR_FMT] = 1'b1;
        step_pos(32'd3);
      end
      ST_FMT_SIZE: begin
        fmt_size[8*lane +: 8] = b;
        step_pos(32'd3);
      end
      ST_FMT_BODY: begin
        if (pos < 16) begin
          if (pos < 2) begin
            fmt_code[8*pos[0] +: 8] = b;
            if (pos == 1 && fmt_code != FMT_PCM) errs[ERR_NOT_PCM] = 1'b1;
          end else if (pos < 4) begin
            chans[8*pos[0] +: 8] = b;
          end else if (pos < 8) begin
            rate[8*lane +: 8] = b;
          end else if (pos >= 14) begin
            bps[8*pos[0] +: 8] = b;
          end
        end
        if ({1'b0, pos} + 33'd1 >= {1'b0, body_len}) begin
          st  = ST_DATA_TAG;
          pos = '0;
        end else begin
          pos = pos + 1;
        end
      end
      ST_DATA_TAG: begin
        if (b != TAG_DATA[lane]) errs[ERR_DATA] = 1'b1;
        step_pos(32'd3);
      end
      ST_DATA_SIZE: begin
        dsize[8*lane +: 8] = b;
        step_pos(32'd3);
      end
      default: begin
        if (errs == '0 && (bps == 16'd8 || bps == 16'd16 || bps == 16'd32)) begin
          w.payload_valid = 1'b1;
          w.payload_byte  = b;
        end
      end
    endcase
    w.header_done     = (st == ST_PAYLOAD);
    w.rate_hz         = rate;
    w.channel_count   = chans;
    w.bits_per_sample = bps;
    w.data_bytes      = dsize;
    w.err_riff        = errs[ERR_RIFF];
    w.err_wave        = errs[ERR_WAVE];
    w.err_fmt         = errs[ERR_FMT];
    w.err_not_pcm     = errs[ERR_NOT_PCM];
    w.err_data        = errs[ERR_DATA];
    return w;
  endfunction

  // Output word once the fixed header below has been read without damage.
  function automatic result_t header_word(input logic pv, input logic [7:0] pb);
    result_t w;
    w                 = '0;
    w.header_done     = 1'b1;
    w.payload_valid   = pv;
    w.payload_byte    = pb;
    w.rate_hz         = 32'hFF00_AC44;
    w.channel_count   = 16'hFFFF;
    w.bits_per_sample = 16'd16;
    w.data_bytes      = 32'hFFFF_FFFF;
    return w;
  endfunction

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : port_watch
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = parse_byte(s_axis_tdata);
        case (cur_pin)
          PIN_CLEAR:   want = '0;
          PIN_DONE:    want = header_word(1'b0, 8'h00);
          PIN_PAYLOAD: want = header_word(1'b1, s_axis_tdata);
          default: ;
        endcase
        expected_words.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[ResultW-1:0]);
        if (expected_words.size() == 0) begin
          flag_error("output word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          check_field("header_done", 32'(got.header_done), 32'(want.header_done));
          check_field("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
          check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
          check_field("rate_hz", got.rate_hz, want.rate_hz);
          check_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
          check_field("bits_per_sample", 32'(got.bits_per_sample),
                      32'(want.bits_per_sample));
          check_field("data_bytes", got.data_bytes, want.data_bytes);
          check_field("err_riff", 32'(got.err_riff), 32'(want.err_riff));
          check_field("err_wave", 32'(got.err_wave), 32'(want.err_wave));
          check_field("err_fmt", 32'(got.err_fmt), 32'(want.err_fmt));
          check_field("err_not_pcm", 32'(got.err_not_pcm), 32'(want.err_not_pcm));
          check_field("err_data", 32'(got.err_data), 32'(want.err_data));
          check_field("zero fill", 32'(m_axis_tdata >> ResultW), 32'd0);
        end
      end
    end
  end

  initial begin : sink
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic offer_byte(input logic [7:0] b, input pin_e pin);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    cur_pin       <= pin;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end while (quiet < StallLimit);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    row_t        plan [50];
    int unsigned spots [18];
    int unsigned src_mix [5];
    int unsigned snk_mix [5];
    int          corrupt_at;
    logic [7:0]  b;
    pin_e        pin;
    // An 18-byte format chunk, so two padding bytes are skipped.
    plan = '{
      '{8'h52, PIN_CLEAR}, '{8'h49, PIN_NONE}, '{8'h46, PIN_NONE}, '{8'h46, PIN_NONE},
      '{8'h00, PIN_NONE},  '{8'hFF, PIN_NONE}, '{8'h00, PIN_NONE}, '{8'hFF, PIN_NONE},
      '{8'h57, PIN_NONE},  '{8'h41, PIN_NONE}, '{8'h56, PIN_NONE}, '{8'h45, PIN_NONE},
      '{8'h66, PIN_NONE},  '{8'h6D, PIN_NONE}, '{8'h74, PIN_NONE}, '{8'h00, PIN_NONE},
      '{8'h12, PIN_NONE},  '{8'h00, PIN_NONE}, '{8'h00, PIN_NONE}, '{8'h00, PIN_NONE},
      '{8'h01, PIN_NONE},  '{8'h00, PIN_NONE}, '{8'hFF, PIN_NONE}, '{8'hFF, PIN_NONE},
      '{8'h44, PIN_NONE},  '{8'hAC, PIN_NONE}, '{8'h00, PIN_NONE}, '{8'hFF, PIN_NONE},
      '{8'hFF, PIN_NONE},  '{8'hFF, PIN_NONE}, '{8'hFF, PIN_NONE}, '{8'hFF, PIN_NONE},
      '{8'h00, PIN_NONE},  '{8'h00, PIN_NONE}, '{8'h10, PIN_NONE}, '{8'h00, PIN_NONE},
      '{8'hAA, PIN_NONE},  '{8'h55, PIN_NONE},
      '{8'h64, PIN_NONE},  '{8'h61, PIN_NONE}, '{8'h74, PIN_NONE}, '{8'h61, PIN_NONE},
      '{8'hFF, PIN_NONE},  '{8'hFF, PIN_NONE}, '{8'hFF, PIN_NONE}, '{8'hFF, PIN_DONE},
      '{8'h00, PIN_PAYLOAD}, '{8'hFF, PIN_PAYLOAD}, '{8'h5A, PIN_PAYLOAD},
      '{8'hA5, PIN_PAYLOAD}
    };
    spots   = '{0, 1, 2, 3, 8, 9, 10, 11, 12, 13, 14, 15, 20, 21, 38, 39, 40, 41};
    src_mix = '{0, 46, 0, 17, 0};
    snk_mix = '{0, 0, 46, 17, 0};

    // In about a third of the runs one tag or format byte is damaged.
    corrupt_at = -1;
    if ($urandom_range(2) == 0) corrupt_at = spots[$urandom_range(17)];

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct  = 17;
    snk_stall_pct = 17;
    foreach (plan[i]) begin
      b   = plan[i].data;
      pin = plan[i].pin;
      if (corrupt_at >= 0) begin
        pin = PIN_NONE;
        if (i == corrupt_at) b = b ^ (8'h01 << $urandom_range(7));
      end
      offer_byte(b, pin);
    end

    for (int p = 0; p < 5; p++) begin
      src_idle_pct  = src_mix[p];
      snk_stall_pct = snk_mix[p];
      if (p == 4) hold_req = 1'b1;
      repeat ((p == 4) ? 100 : 200) offer_byte(8'($urandom_range(255)), PIN_NONE);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
